// ===== hw/rtl/dhpm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dhpm_pkg: shared types and constants of the point map core
// widths of the request and result fields, coefficient slots, codes
// ----------------------------------------------------------------------------
package dhpm_pkg;

  // default configuration
  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned COEF_FRAC_DEF  = 24;

  // field widths
  localparam int unsigned COEF_W    = 48;
  localparam int unsigned SLOT_W    = 5;
  localparam int unsigned COL_W     = 12;
  localparam int unsigned DISP_W    = 16;
  localparam int unsigned DISP_FRAC = 4;
  localparam int unsigned MASK_W    = 8;
  localparam int unsigned OUT_W     = 24;
  localparam int unsigned OUT_FRAC  = 8;

  // coefficient store layout
  localparam int unsigned NUM_SLOTS   = 22;
  localparam int unsigned HOMOG_N     = 11;
  localparam int unsigned SLOT_FIRST  = 0;
  localparam int unsigned SLOT_SECOND = 11;
  localparam int unsigned OFF_X       = 9;
  localparam int unsigned OFF_Y       = 10;

  // pipeline depth of the two halves
  localparam int unsigned FRONT_ST = 4;
  localparam int unsigned LANE_ST  = OUT_W + 3;

  localparam logic signed [DISP_W-1:0] DISP_NONE = -16'sd160;
  localparam logic [MASK_W-1:0]        MASK_FULL = 8'hFF;
  localparam logic [OUT_W-1:0]         OUT_POS_MAX = 24'h7FFFFF;
  localparam logic [OUT_W-1:0]         OUT_NEG_MAX = 24'h800000;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_MAP  = 1'b1
  } dhpm_action_e;

  typedef enum logic [1:0] {
    ST_MAPPED   = 2'd0,
    ST_SKIPPED  = 2'd1,
    ST_ZERO_DEN = 2'd2
  } dhpm_status_e;

  typedef logic signed [COEF_W-1:0] dhpm_coef_t;

  typedef struct packed {
    dhpm_action_e              action;
    logic [SLOT_W-1:0]         coef_index;
    logic signed [COEF_W-1:0]  coef_value;
    logic [COL_W-1:0]          pixel_col;
    logic [COL_W-1:0]          pixel_row;
    logic signed [DISP_W-1:0]  disparity;
    logic [MASK_W-1:0]         mask_value;
  } dhpm_req_t;

  typedef struct packed {
    dhpm_status_e             map_status;
    logic signed [OUT_W-1:0]  first_x;
    logic signed [OUT_W-1:0]  first_y;
    logic signed [OUT_W-1:0]  second_x;
    logic signed [OUT_W-1:0]  second_y;
  } dhpm_res_t;

  typedef struct packed {
    logic skip;
    logic zero_den;
  } dhpm_meta_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dhpm_stream_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dhpm_stream_if: valid/ready channel
// one request moves at a clock edge with valid and ready both high
// ----------------------------------------------------------------------------
interface dhpm_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/dhpm_coef_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dhpm_coef_store: homography coefficient registers
// 22 signed entries, cleared by reset, one write per load request
// ----------------------------------------------------------------------------
module dhpm_coef_store (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              we_i,
  input  logic [dhpm_pkg::SLOT_W-1:0]       idx_i,
  input  dhpm_pkg::dhpm_coef_t              val_i,
  output dhpm_pkg::dhpm_coef_t              coef_o [dhpm_pkg::NUM_SLOTS]
);

  dhpm_pkg::dhpm_coef_t store_q [dhpm_pkg::NUM_SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dhpm_pkg::NUM_SLOTS; i++) begin
        store_q[i] <= '0;
      end
    end else if (we_i && (idx_i < dhpm_pkg::SLOT_W'(dhpm_pkg::NUM_SLOTS))) begin
      store_q[idx_i] <= val_i;
    end
  end

  assign coef_o = store_q;

endmodule
`default_nettype wire

// ===== hw/rtl/dhpm_proj.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dhpm_proj: offset, matrix multiply and sums for one homography
// four stages: offset add, partial products, products, row sums
// ----------------------------------------------------------------------------
module dhpm_proj #(
  parameter int unsigned PT_W      = 49,
  parameter int unsigned FRAC_BITS = dhpm_pkg::COEF_FRAC_DEF,
  localparam int unsigned SUM_W    = dhpm_pkg::COEF_W + PT_W + 2
) (
  input  logic                              clk_i,
  input  logic [dhpm_pkg::FRONT_ST-1:0]     en_i,
  input  logic signed [PT_W-1:0]            x_i,
  input  logic signed [PT_W-1:0]            y_i,
  input  dhpm_pkg::dhpm_coef_t              coef_i [dhpm_pkg::HOMOG_N],
  output logic signed [SUM_W-1:0]           num_x_o,
  output logic signed [SUM_W-1:0]           num_y_o,
  output logic signed [SUM_W-1:0]           den_o
);

  localparam int unsigned AL   = dhpm_pkg::COEF_W / 2;
  localparam int unsigned AH   = dhpm_pkg::COEF_W - AL;
  localparam int unsigned BL   = PT_W / 2;
  localparam int unsigned BH   = PT_W - BL;
  localparam int unsigned PR_W = dhpm_pkg::COEF_W + PT_W;

  logic signed [PT_W-1:0]      x_q, y_q;
  logic [AL+BL-1:0]            ll_q [6];
  logic signed [AH+BL:0]       hl_q [6];
  logic signed [AL+BH:0]       lh_q [6];
  logic signed [AH+BH-1:0]     hh_q [6];
  logic signed [PR_W-1:0]      pr_q [6];
  logic signed [SUM_W-1:0]     sh1_q [3];
  logic signed [SUM_W-1:0]     sh2_q [3];
  logic signed [SUM_W-1:0]     sum_q [3];

  // point plus offset
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      x_q <= x_i + PT_W'(coef_i[dhpm_pkg::OFF_X]);
      y_q <= y_i + PT_W'(coef_i[dhpm_pkg::OFF_Y]);
    end
  end

  // six products, each split in four partial products
  for (genvar p = 0; p < 6; p++) begin : g_prod
    localparam int unsigned R = p / 2;
    localparam int unsigned C = p % 2;
    logic [AL-1:0]          a_lo;
    logic signed [AH-1:0]   a_hi;
    logic [BL-1:0]          b_lo;
    logic signed [BH-1:0]   b_hi;
    logic signed [PT_W-1:0] pt;

    assign pt   = (C == 0) ? x_q : y_q;
    assign a_lo = coef_i[3*R+C][AL-1:0];
    assign a_hi = coef_i[3*R+C][dhpm_pkg::COEF_W-1:AL];
    assign b_lo = pt[BL-1:0];
    assign b_hi = pt[PT_W-1:BL];

    always_ff @(posedge clk_i) begin
      if (en_i[1]) begin
        ll_q[p] <= a_lo * b_lo;
        hl_q[p] <= a_hi * $signed({1'b0, b_lo});
        lh_q[p] <= $signed({1'b0, a_lo}) * b_hi;
        hh_q[p] <= a_hi * b_hi;
      end
      if (en_i[2]) begin
        pr_q[p] <= (PR_W'(hh_q[p]) <<< (AL + BL)) + (PR_W'(hl_q[p]) <<< AL)
                 + (PR_W'(lh_q[p]) <<< BL) + PR_W'(ll_q[p]);
      end
    end
  end

  // third column times the homogeneous one is a shift
  for (genvar r = 0; r < 3; r++) begin : g_row
    always_ff @(posedge clk_i) begin
      if (en_i[1]) begin
        sh1_q[r] <= SUM_W'(coef_i[3*r+2]) <<< FRAC_BITS;
      end
      if (en_i[2]) begin
        sh2_q[r] <= sh1_q[r];
      end
      if (en_i[3]) begin
        sum_q[r] <= SUM_W'(pr_q[2*r]) + SUM_W'(pr_q[2*r+1]) + sh2_q[r];
      end
    end
  end

  assign num_x_o = sum_q[0];
  assign num_y_o = sum_q[1];
  assign den_o   = sum_q[2];

endmodule
`default_nettype wire

// ===== hw/rtl/dhpm_div_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dhpm_div_lane: pipelined restoring divide, one quotient bit per stage
// returns (num * 256) / den toward zero, saturated to signed 24 bits
// ----------------------------------------------------------------------------
module dhpm_div_lane #(
  parameter int unsigned SUM_W = 99
) (
  input  logic                              clk_i,
  input  logic [dhpm_pkg::LANE_ST-1:0]      en_i,
  input  logic signed [SUM_W-1:0]           num_i,
  input  logic signed [SUM_W-1:0]           den_i,
  output logic [dhpm_pkg::OUT_W-1:0]        quo_o
);

  localparam int unsigned QW   = dhpm_pkg::OUT_W;
  localparam int unsigned RW   = SUM_W + QW;
  localparam int unsigned LAST = QW + 1;

  logic [SUM_W-1:0] n_mag, d_mag;
  logic [RW-1:0]    rem_q [0:QW];
  logic [SUM_W-1:0] d_q   [0:QW];
  logic             neg_q [0:LAST];
  logic             sat_q [1:LAST];
  logic [QW-1:0]    quo_q [1:LAST];
  logic [QW-1:0]    res_q;

  assign n_mag = num_i[SUM_W-1] ? SUM_W'(-num_i) : SUM_W'(num_i);
  assign d_mag = den_i[SUM_W-1] ? SUM_W'(-den_i) : SUM_W'(den_i);

  // magnitudes and sign
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0] <= RW'(n_mag) << dhpm_pkg::OUT_FRAC;
      d_q[0]   <= d_mag;
      neg_q[0] <= num_i[SUM_W-1] ^ den_i[SUM_W-1];
    end
  end

  // quotient of 2^24 or more saturates either way
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      sat_q[1] <= rem_q[0] >= (RW'(d_q[0]) << QW);
      rem_q[1] <= rem_q[0];
      d_q[1]   <= d_q[0];
      neg_q[1] <= neg_q[0];
      quo_q[1] <= '0;
    end
  end

  for (genvar j = 2; j <= LAST; j++) begin : g_step
    localparam int unsigned K = LAST - j;
    logic [RW:0] trial;

    assign trial = {1'b0, rem_q[j-1]} - {1'b0, RW'(d_q[j-1]) << K};

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        quo_q[j] <= quo_q[j-1] | (trial[RW] ? QW'(0) : (QW'(1) << K));
        sat_q[j] <= sat_q[j-1];
        neg_q[j] <= neg_q[j-1];
      end
    end

    if (j <= QW) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i[j]) begin
          rem_q[j] <= trial[RW] ? rem_q[j-1] : trial[RW-1:0];
          d_q[j]   <= d_q[j-1];
        end
      end
    end
  end

  // sign and saturation
  always_ff @(posedge clk_i) begin
    if (en_i[LAST+1]) begin
      if (neg_q[LAST]) begin
        if (sat_q[LAST] || (quo_q[LAST][QW-1] && (|quo_q[LAST][QW-2:0]))) begin
          res_q <= dhpm_pkg::OUT_NEG_MAX;
        end else begin
          res_q <= QW'(-quo_q[LAST]);
        end
      end else begin
        if (sat_q[LAST] || quo_q[LAST][QW-1]) begin
          res_q <= dhpm_pkg::OUT_POS_MAX;
        end else begin
          res_q <= quo_q[LAST];
        end
      end
    end
  end

  assign quo_o = res_q;

endmodule
`default_nettype wire

// ===== hw/rtl/disparity_homography_point_map_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// disparity_homography_point_map_core: stereo pixel to two-image point map
// maps each rectified pixel through two homographies with projective divide
// ----------------------------------------------------------------------------
//
//  channel | dir | payload     | carries
//  --------+-----+-------------+---------------------------------------------
//  req_i   | in  | dhpm_req_t  | coefficient load or pixel map request
//  res_o   | out | dhpm_res_t  | status and four Q15.8 coordinates per pixel
//
// one request per cycle while req_i.ready is high, loads and maps alike; a map
// result passes 4 multiply/sum stages, 27 divide stages and the output
// register; a load gives no result
// every stage has its own valid bit and moves when the next one is free, so
// a stalled result only holds the stages up to the first empty one
// reset clears the valid bits and the coefficient store, payload is not reset
// a load waits while a stalled pixel sits in the first (offset) stage
//
module disparity_homography_point_map_core #(
  parameter int unsigned COORD_BITS     = dhpm_pkg::COORD_BITS_DEF,
  parameter int unsigned COEF_FRAC_BITS = dhpm_pkg::COEF_FRAC_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  dhpm_stream_if.sink      req_i,
  dhpm_stream_if.source    res_o
);

  // coordinate bits actually used
  localparam int unsigned CB    = (COORD_BITS < dhpm_pkg::COL_W) ? COORD_BITS
                                                                 : dhpm_pkg::COL_W;
  localparam int unsigned RAW1  = CB + COEF_FRAC_BITS + 1;
  localparam int unsigned RAW2  = dhpm_pkg::DISP_W + COEF_FRAC_BITS - dhpm_pkg::DISP_FRAC;
  localparam int unsigned RAWX  = ((RAW1 > RAW2) ? RAW1 : RAW2) + 1;
  localparam int unsigned PT_W  = ((RAWX > dhpm_pkg::COEF_W) ? RAWX : dhpm_pkg::COEF_W) + 1;
  localparam int unsigned SUM_W = dhpm_pkg::COEF_W + PT_W + 2;
  localparam int unsigned FST   = dhpm_pkg::FRONT_ST;
  localparam int unsigned NST   = dhpm_pkg::FRONT_ST + dhpm_pkg::LANE_ST;

  // handshake and stage control
  logic [NST:0]        rdy;
  logic [NST-1:0]      v_q, v_d;
  logic                out_v_q;
  logic                req_acc;
  logic                load_we;

  dhpm_pkg::dhpm_meta_t meta_q [NST];
  dhpm_pkg::dhpm_meta_t meta_d [NST];

  // datapath
  dhpm_pkg::dhpm_coef_t   coef   [dhpm_pkg::NUM_SLOTS];
  dhpm_pkg::dhpm_coef_t   coef_a [dhpm_pkg::HOMOG_N];
  dhpm_pkg::dhpm_coef_t   coef_b [dhpm_pkg::HOMOG_N];
  logic [CB-1:0]          col_m, row_m;
  logic signed [PT_W-1:0] x1_raw, y1_raw, x2_raw, disp_sh;
  logic signed [SUM_W-1:0] nx_a, ny_a, den_a, nx_b, ny_b, den_b;
  logic [dhpm_pkg::OUT_W-1:0] fx, fy, sx, sy;
  logic                   skip;
  dhpm_pkg::dhpm_status_e status;
  dhpm_pkg::dhpm_res_t    res_q;

  // a stage accepts when empty or when its content moves on
  assign rdy[NST] = !out_v_q || res_o.ready;
  for (genvar k = 0; k < NST; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end

  assign req_i.ready = rdy[0];
  assign req_acc     = req_i.valid && rdy[0];
  assign load_we     = req_acc && (req_i.data.action == dhpm_pkg::ACT_LOAD);

  always_comb begin
    v_d[0] = rdy[0] ? (req_i.valid && (req_i.data.action == dhpm_pkg::ACT_MAP)) : v_q[0];
    for (int k = 1; k < NST; k++) begin
      v_d[k] = rdy[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else begin
      v_q <= v_d;
      if (rdy[NST]) begin
        out_v_q <= v_q[NST-1];
      end
    end
  end

  // coefficient store, read by the offset and multiply stages only
  dhpm_coef_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (load_we),
    .idx_i  (req_i.data.coef_index),
    .val_i  (req_i.data.coef_value),
    .coef_o (coef)
  );

  always_comb begin
    for (int i = 0; i < dhpm_pkg::HOMOG_N; i++) begin
      coef_a[i] = coef[dhpm_pkg::SLOT_FIRST + i];
      coef_b[i] = coef[dhpm_pkg::SLOT_SECOND + i];
    end
  end

  // pixel to fixed-point points; second point shifted by the disparity
  assign col_m   = req_i.data.pixel_col[CB-1:0];
  assign row_m   = req_i.data.pixel_row[CB-1:0];
  assign x1_raw  = $signed(PT_W'(col_m) << COEF_FRAC_BITS);
  assign y1_raw  = $signed(PT_W'(row_m) << COEF_FRAC_BITS);
  assign disp_sh = PT_W'(req_i.data.disparity) <<< (COEF_FRAC_BITS - dhpm_pkg::DISP_FRAC);
  assign x2_raw  = x1_raw - disp_sh;

  // no disparity or partial mask
  assign skip = (req_i.data.disparity == dhpm_pkg::DISP_NONE)
             || (req_i.data.mask_value != dhpm_pkg::MASK_FULL);

  dhpm_proj #(
    .PT_W      (PT_W),
    .FRAC_BITS (COEF_FRAC_BITS)
  ) u_proj_a (
    .clk_i   (clk_i),
    .en_i    (rdy[FST-1:0]),
    .x_i     (x1_raw),
    .y_i     (y1_raw),
    .coef_i  (coef_a),
    .num_x_o (nx_a),
    .num_y_o (ny_a),
    .den_o   (den_a)
  );

  dhpm_proj #(
    .PT_W      (PT_W),
    .FRAC_BITS (COEF_FRAC_BITS)
  ) u_proj_b (
    .clk_i   (clk_i),
    .en_i    (rdy[FST-1:0]),
    .x_i     (x2_raw),
    .y_i     (y1_raw),
    .coef_i  (coef_b),
    .num_x_o (nx_b),
    .num_y_o (ny_b),
    .den_o   (den_b)
  );

  // four divide lanes, both lanes of a point share its denominator
  dhpm_div_lane #(.SUM_W(SUM_W)) u_div_fx (
    .clk_i (clk_i), .en_i (rdy[NST-1:FST]), .num_i (nx_a), .den_i (den_a), .quo_o (fx)
  );
  dhpm_div_lane #(.SUM_W(SUM_W)) u_div_fy (
    .clk_i (clk_i), .en_i (rdy[NST-1:FST]), .num_i (ny_a), .den_i (den_a), .quo_o (fy)
  );
  dhpm_div_lane #(.SUM_W(SUM_W)) u_div_sx (
    .clk_i (clk_i), .en_i (rdy[NST-1:FST]), .num_i (nx_b), .den_i (den_b), .quo_o (sx)
  );
  dhpm_div_lane #(.SUM_W(SUM_W)) u_div_sy (
    .clk_i (clk_i), .en_i (rdy[NST-1:FST]), .num_i (ny_b), .den_i (den_b), .quo_o (sy)
  );

  // per-stage flags travel beside the data
  always_comb begin
    meta_d[0].skip     = skip;
    meta_d[0].zero_den = 1'b0;
    for (int k = 1; k < NST; k++) begin
      meta_d[k] = meta_q[k-1];
    end
    // denominators leave the sum stage here
    meta_d[FST].zero_den = (den_a == '0) || (den_b == '0);
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NST; k++) begin
      if (rdy[k]) begin
        meta_q[k] <= meta_d[k];
      end
    end
  end

  // result: a skip wins over a zero denominator, fields clear unless mapped
  always_comb begin
    if (meta_q[NST-1].skip) begin
      status = dhpm_pkg::ST_SKIPPED;
    end else if (meta_q[NST-1].zero_den) begin
      status = dhpm_pkg::ST_ZERO_DEN;
    end else begin
      status = dhpm_pkg::ST_MAPPED;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NST]) begin
      res_q.map_status <= status;
      if (status == dhpm_pkg::ST_MAPPED) begin
        res_q.first_x  <= fx;
        res_q.first_y  <= fy;
        res_q.second_x <= sx;
        res_q.second_y <= sy;
      end else begin
        res_q.first_x  <= '0;
        res_q.first_y  <= '0;
        res_q.second_x <= '0;
        res_q.second_y <= '0;
      end
    end
  end

  assign res_o.valid = out_v_q;
  assign res_o.data  = res_q;

`ifndef SYNTH
  // a stalled pixel in the first stage still reads the store: nothing may enter
  a_store_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[0] && !rdy[1]) |-> !req_i.ready)
    else $error("request taken while first stage is stalled");

  // a finished pixel moves into the output register
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NST-1] && rdy[NST]) |=> out_v_q)
    else $error("result lost at output register");

  // unmapped results carry zero coordinates
  a_unmapped_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && (res_q.map_status != dhpm_pkg::ST_MAPPED)) |->
      ((res_q.first_x == '0) && (res_q.first_y == '0)
       && (res_q.second_x == '0) && (res_q.second_y == '0)))
    else $error("skipped or degenerate result with nonzero coordinates");
`endif

endmodule
`default_nettype wire
